// ===== src/obla_pkg.sv =====
// Shared types and constants for the order book level aggregator.
// No dependencies; used by obla_front, obla_back and the top level.
package obla_pkg;

	localparam int ORDER_SLOTS_DEF  = 65536;
	localparam int PRICE_LEVELS_DEF = 4096;

	localparam logic [2:0] KIND_ADD     = 3'd0;
	localparam logic [2:0] KIND_EXECUTE = 3'd1;
	localparam logic [2:0] KIND_CANCEL  = 3'd2;
	localparam logic [2:0] KIND_DELETE  = 3'd3;
	localparam logic [2:0] KIND_REPLACE = 3'd4;
	localparam logic [2:0] KIND_QUERY   = 3'd5;

	// One queued feed event, as classified by the front end.
	typedef struct packed {
		logic [2:0]  kind;
		logic        slot_op;
		logic [15:0] ord_ix;
		logic [15:0] repl_ix;
		logic        side;
		logic [11:0] price;
		logic [31:0] quantity;
	} cmd_t;

	// One result item.
	typedef struct packed {
		logic               found;
		logic               bid_present;
		logic [11:0]        bid_px;
		logic               ask_present;
		logic [11:0]        ask_px;
		logic signed [12:0] spread;
		logic [11:0]        mid_px;
		logic [31:0]        level_quantity;
	} res_t;

endpackage

// ===== src/obla_front.sv =====
// Front end: accepts feed events, classifies them and queues them (two entries).
// Depends on obla_pkg.
module obla_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [2:0]          kind,
	input  logic [15:0]         ord_ix,
	input  logic [15:0]         repl_ix,
	input  logic                side,
	input  logic [11:0]         price,
	input  logic [31:0]         quantity,
	output logic                cmd_valid,
	output obla_pkg::cmd_t      cmd,
	input  logic                cmd_pop
);

	obla_pkg::cmd_t fifo_q [2];
	obla_pkg::cmd_t entry;
	logic           wr_q, rd_q;
	logic [1:0]     cnt_q;
	logic           push;

	assign in_ready  = (cnt_q != 2'd2);
	assign push      = in_valid && in_ready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = fifo_q[rd_q];

	always_comb begin
		entry.kind     = kind;
		// events that must look up an existing order first
		entry.slot_op  = (kind == obla_pkg::KIND_EXECUTE) || (kind == obla_pkg::KIND_CANCEL) ||
			(kind == obla_pkg::KIND_DELETE) || (kind == obla_pkg::KIND_REPLACE);
		entry.ord_ix   = ord_ix;
		entry.repl_ix  = repl_ix;
		entry.side     = side;
		entry.price    = price;
		entry.quantity = quantity;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (cmd_pop) rd_q <= ~rd_q;
			unique case ({push, cmd_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== src/obla_back.sv =====
// Back end: order table, level totals, top-of-book tracking and result build.
// Depends on obla_pkg.
module obla_back #(
	parameter int ORDER_SLOTS  = obla_pkg::ORDER_SLOTS_DEF,
	parameter int PRICE_LEVELS = obla_pkg::PRICE_LEVELS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  obla_pkg::cmd_t cmd,
	output logic           cmd_pop,
	output logic           res_valid,
	output obla_pkg::res_t res,
	input  logic           res_ready
);

	localparam int OW    = $clog2(ORDER_SLOTS);
	localparam int PW    = $clog2(PRICE_LEVELS);
	localparam int LW    = PW + 1;
	localparam int CLR_N = (ORDER_SLOTS > 2 * PRICE_LEVELS) ? ORDER_SLOTS : 2 * PRICE_LEVELS;
	localparam int CW    = $clog2(CLR_N);
	localparam logic [PW-1:0] P_TOP = PW'(PRICE_LEVELS - 1);

	typedef struct packed {
		logic          vld;
		logic          side;
		logic [PW-1:0] price;
		logic [31:0]   rem;
	} slot_t;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_SDEC, S_LRD, S_LUPD, S_SCRD, S_SCCHK, S_QRD, S_QOUT
	} state_t;

	state_t         st_q;
	obla_pkg::cmd_t cmd_q;
	logic [CW-1:0]  clr_q;
	logic           lop_side_q, lop_add_q, enter_pend_q, found_q;
	logic [PW-1:0]  lop_price_q, scan_q;
	logic [31:0]    lop_qty_q;
	logic [OW-1:0]  lop_ix_q;
	logic           bid_any_q, ask_any_q;
	logic [PW-1:0]  top_bid_q, top_ask_q;

	slot_t          slot_mem [ORDER_SLOTS];
	slot_t          slot_rd_q, slot_wd;
	logic           slot_we;
	logic [OW-1:0]  slot_wa, slot_ra;
	logic [31:0]    lvl_mem [2 * PRICE_LEVELS];
	logic [31:0]    lvl_rd_q, lvl_wd;
	logic           lvl_we;
	logic [LW-1:0]  lvl_wa, lvl_ra;

	logic [OW-1:0]  cid, nid;
	logic [PW-1:0]  cpr;
	logic [31:0]    take, rem_left, new_tot;
	logic [32:0]    sum;
	logic           new_nz, start_scan, hit, scan_end, lvl_done;
	logic [PW-1:0]  bb, ba;
	logic [31:0]    diff, msum;

	assign cid     = OW'(cmd_q.ord_ix);
	assign nid     = OW'(cmd_q.repl_ix);
	assign cpr     = PW'(cmd_q.price);
	assign slot_ra = OW'(cmd.ord_ix);
	assign cmd_pop = (st_q == S_IDLE) && cmd_valid;

	// clamp execute/cancel to what remains
	assign take     = (cmd_q.quantity < slot_rd_q.rem) ? cmd_q.quantity : slot_rd_q.rem;
	assign rem_left = slot_rd_q.rem - take;

	// saturating add, flooring subtract
	assign sum     = {1'b0, lvl_rd_q} + {1'b0, lop_qty_q};
	assign new_tot = lop_add_q ? (sum[32] ? 32'hFFFF_FFFF : sum[31:0]) :
		((lvl_rd_q > lop_qty_q) ? (lvl_rd_q - lop_qty_q) : 32'd0);
	assign new_nz  = (new_tot != 32'd0);

	assign start_scan = !new_nz && (
		(!lop_side_q && bid_any_q && lop_price_q == top_bid_q && lop_price_q != '0) ||
		( lop_side_q && ask_any_q && lop_price_q == top_ask_q && lop_price_q != P_TOP));
	assign hit      = (lvl_rd_q != 32'd0);
	assign scan_end = lop_side_q ? (scan_q == P_TOP) : (scan_q == '0);
	assign lvl_done = ((st_q == S_LUPD) && !start_scan) || ((st_q == S_SCCHK) && (hit || scan_end));

	always_comb begin
		slot_we = 1'b0;
		slot_wa = cid;
		slot_wd = slot_rd_q;
		lvl_we  = 1'b0;
		lvl_wa  = {lop_side_q, lop_price_q};
		lvl_wd  = new_tot;
		lvl_ra  = {cmd_q.side, cpr};
		unique case (st_q)
			S_CLR: begin
				slot_we = ({1'b0, clr_q} < (CW + 1)'(ORDER_SLOTS));
				slot_wa = clr_q[OW-1:0];
				slot_wd = '0;
				lvl_we  = ({1'b0, clr_q} < (CW + 1)'(2 * PRICE_LEVELS));
				lvl_wa  = clr_q[LW-1:0];
				lvl_wd  = 32'd0;
			end
			S_SDEC: begin
				if (cmd_q.slot_op && slot_rd_q.vld) begin
					slot_we = 1'b1;
					if (cmd_q.kind == obla_pkg::KIND_EXECUTE ||
						cmd_q.kind == obla_pkg::KIND_CANCEL) begin
						slot_wd.rem = rem_left;
						slot_wd.vld = (rem_left != 32'd0);
					end else begin
						slot_wd.vld = 1'b0;
					end
				end
			end
			S_LRD: begin
				lvl_ra = {lop_side_q, lop_price_q};
				if (lop_add_q) begin
					slot_we = 1'b1;
					slot_wa = lop_ix_q;
					slot_wd = {1'b1, lop_side_q, lop_price_q, lop_qty_q};
				end
			end
			S_LUPD: lvl_we = 1'b1;
			S_SCRD: lvl_ra = {lop_side_q, scan_q};
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (slot_we) slot_mem[slot_wa] <= slot_wd;
		slot_rd_q <= slot_mem[slot_ra];
	end

	always_ff @(posedge clk) begin
		if (lvl_we) lvl_mem[lvl_wa] <= lvl_wd;
		lvl_rd_q <= lvl_mem[lvl_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= S_CLR;
			clr_q        <= '0;
			enter_pend_q <= 1'b0;
			found_q      <= 1'b0;
			lop_add_q    <= 1'b0;
			bid_any_q    <= 1'b0;
			ask_any_q    <= 1'b0;
		end else begin
			unique case (st_q)
				S_CLR: begin
					clr_q <= clr_q + CW'(1);
					if (clr_q == CW'(CLR_N - 1)) st_q <= S_IDLE;
				end
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q <= cmd;
						st_q  <= S_SDEC;
					end
				end
				S_SDEC: begin
					priority if (cmd_q.kind == obla_pkg::KIND_ADD) begin
						found_q      <= 1'b1;
						lop_side_q   <= cmd_q.side;
						lop_price_q  <= cpr;
						lop_qty_q    <= cmd_q.quantity;
						lop_add_q    <= 1'b1;
						lop_ix_q     <= cid;
						enter_pend_q <= 1'b0;
						st_q         <= S_LRD;
					end else if (cmd_q.slot_op) begin
						found_q <= slot_rd_q.vld;
						if (slot_rd_q.vld) begin
							lop_side_q   <= slot_rd_q.side;
							lop_price_q  <= slot_rd_q.price;
							lop_add_q    <= 1'b0;
							lop_qty_q    <= (cmd_q.kind == obla_pkg::KIND_EXECUTE ||
								cmd_q.kind == obla_pkg::KIND_CANCEL) ? take : slot_rd_q.rem;
							enter_pend_q <= (cmd_q.kind == obla_pkg::KIND_REPLACE);
							st_q         <= S_LRD;
						end else begin
							st_q <= S_QRD;
						end
					end else begin
						found_q <= (cmd_q.kind == obla_pkg::KIND_QUERY);
						st_q    <= S_QRD;
					end
				end
				S_LRD: st_q <= S_LUPD;
				S_LUPD: begin
					if (new_nz) begin
						if (!lop_side_q) begin
							if (!bid_any_q || lop_price_q > top_bid_q) begin
								top_bid_q <= lop_price_q;
								bid_any_q <= 1'b1;
							end
						end else if (!ask_any_q || lop_price_q < top_ask_q) begin
							top_ask_q <= lop_price_q;
							ask_any_q <= 1'b1;
						end
					end else if (!lop_side_q && bid_any_q && lop_price_q == top_bid_q) begin
						bid_any_q <= 1'b0;
						scan_q    <= lop_price_q - PW'(1);
					end else if (lop_side_q && ask_any_q && lop_price_q == top_ask_q) begin
						ask_any_q <= 1'b0;
						scan_q    <= lop_price_q + PW'(1);
					end
					if (start_scan) st_q <= S_SCRD;
				end
				S_SCRD: st_q <= S_SCCHK;
				S_SCCHK: begin
					if (hit) begin
						if (!lop_side_q) begin
							top_bid_q <= scan_q;
							bid_any_q <= 1'b1;
						end else begin
							top_ask_q <= scan_q;
							ask_any_q <= 1'b1;
						end
					end else if (!scan_end) begin
						scan_q <= lop_side_q ? (scan_q + PW'(1)) : (scan_q - PW'(1));
						st_q   <= S_SCRD;
					end
				end
				S_QRD: st_q <= S_QOUT;
				S_QOUT: if (res_ready) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase

			// level update finished: enter the replacement, or go to the level read
			if (lvl_done) begin
				if (enter_pend_q) begin
					enter_pend_q <= 1'b0;
					lop_side_q   <= cmd_q.side;
					lop_price_q  <= cpr;
					lop_qty_q    <= cmd_q.quantity;
					lop_add_q    <= 1'b1;
					lop_ix_q     <= nid;
					st_q         <= S_LRD;
				end else begin
					st_q <= S_QRD;
				end
			end
		end
	end

	assign bb        = bid_any_q ? top_bid_q : '0;
	assign ba        = ask_any_q ? top_ask_q : '0;
	assign diff      = 32'(ba) - 32'(bb);
	assign msum      = 32'(ba) + 32'(bb);
	assign res_valid = (st_q == S_QOUT);

	always_comb begin
		res.found          = found_q;
		res.bid_present    = bid_any_q;
		res.bid_px         = 12'(bb);
		res.ask_present    = ask_any_q;
		res.ask_px         = 12'(ba);
		res.spread         = (bid_any_q && ask_any_q) ? diff[12:0] : 13'sd0;
		res.mid_px         = (bid_any_q && ask_any_q) ? msum[12:1] : 12'd0;
		res.level_quantity = lvl_rd_q;
	end

endmodule

// ===== src/order_book_level_aggregator_unit.sv =====
// Top level of the order book level aggregator: front end, back end, output register.
// Depends on obla_pkg, obla_front and obla_back.
//
// Usage:
//  - Input channel (in_valid/in_ready) carries one feed event per transfer:
//    add, execute, cancel, delete, replace or level query.
//  - Output channel (out_valid/out_ready) returns exactly one result per event,
//    in order: found flag, top of book, spread, floored mid and one level total.
//  - A two-entry queue in the front end takes events while the back end works.
//  - Per event the back end does no level update for a query or unknown id,
//    one for add/execute/cancel/delete and two for replace; each level update is a
//    read then write of the level-total memory (single port pair).
//  - When the best level of a side empties, the next best is found by walking
//    the level memory of that side, visiting at most PRICE_LEVELS-1 levels.
//  - Each result passes through the output register.
//  - After reset a clearing pass over max(ORDER_SLOTS, 2*PRICE_LEVELS) entries
//    zeroes the order table and level totals; no event leaves the queue until
//    it ends.
//  - If the receiver stalls, the result waits in the output register, the back
//    end holds its next result, and in_ready drops once the queue is full.
//  - Order ids and prices wrap modulo ORDER_SLOTS and PRICE_LEVELS (powers of two).
module order_book_level_aggregator_unit #(
	parameter int ORDER_SLOTS  = obla_pkg::ORDER_SLOTS_DEF,
	parameter int PRICE_LEVELS = obla_pkg::PRICE_LEVELS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         kind,
	input  logic [15:0]        ord_ix,
	input  logic [15:0]        repl_ix,
	input  logic               side,
	input  logic [11:0]        price,
	input  logic [31:0]        quantity,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               found,
	output logic               bid_present,
	output logic [11:0]        bid_px,
	output logic               ask_present,
	output logic [11:0]        ask_px,
	output logic signed [12:0] spread,
	output logic [11:0]        mid_px,
	output logic [31:0]        level_quantity
);

	obla_pkg::cmd_t cmd;
	logic           cmd_valid, cmd_pop;
	obla_pkg::res_t res, out_q;
	logic           res_valid, res_ready, out_vld_q;

	obla_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.ord_ix    (ord_ix),
		.repl_ix   (repl_ix),
		.side      (side),
		.price     (price),
		.quantity  (quantity),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	obla_back #(
		.ORDER_SLOTS  (ORDER_SLOTS),
		.PRICE_LEVELS (PRICE_LEVELS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready)
	);

	// output register: free, or emptied by this transfer
	assign res_ready = !out_vld_q || out_ready;

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) out_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_ready) begin
			out_vld_q <= res_valid;
		end
	end

	assign out_valid      = out_vld_q;
	assign found          = out_q.found;
	assign bid_present    = out_q.bid_present;
	assign bid_px         = out_q.bid_px;
	assign ask_present    = out_q.ask_present;
	assign ask_px         = out_q.ask_px;
	assign spread         = out_q.spread;
	assign mid_px         = out_q.mid_px;
	assign level_quantity = out_q.level_quantity;

	// back end must hold a result it could not hand over
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while output register full");

	// an empty bid side reports zero price, spread and mid
	a_bid_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !bid_present |-> bid_px == 12'd0 && spread == 13'sd0 && mid_px == 12'd0)
		else $error("empty bid side with nonzero prices");

	// an empty ask side reports zero price, spread and mid
	a_ask_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ask_present |-> ask_px == 12'd0 && spread == 13'sd0 && mid_px == 12'd0)
		else $error("empty ask side with nonzero prices");

endmodule
